/* rtl/ssfs_pkg.sv */
// Shared widths, codes and control types of the sprite-sheet frame sequencer.
package ssfs_pkg;

  localparam int FRAME_BITS = 12;
  localparam int TIME_BITS  = 24;

  // Fixed field widths
  localparam int FCFG_W     = 12;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 12;
  localparam int PERIOD_W   = 24;
  localparam int DT_W       = 16;
  localparam int OP_W       = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Offset and frame arithmetic
  localparam int OFS_W      = FCFG_W + 1;
  localparam int ARITH_W    = ((FRAME_BITS + 1) > (FCFG_W + 2)) ? (FRAME_BITS + 1) : (FCFG_W + 2);
  localparam int FRAME_MAX  = (1 << FRAME_BITS) - 1;

  // Time accumulator
  localparam int SUM_W      = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
  localparam int CMP_W      = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

  // Divider step counter
  localparam int CNT_W      = $clog2(FRAME_BITS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd4;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic map_load;
    logic out_load;
  } ssfs_cmd_t;

  typedef struct packed {
    logic need_div;
  } ssfs_sts_t;

endpackage

/* rtl/ssfs_req_if.sv */
// Request channel: operation and elapsed time.
interface ssfs_req_if import ssfs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [DT_W-1:0] delta_time;

  modport source (output valid, output operation, output delta_time, input ready);
  modport sink   (input valid, input operation, input delta_time, output ready);
endinterface

/* rtl/ssfs_rsp_if.sv */
// Response channel: sheet position and animation status.
interface ssfs_rsp_if import ssfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic             playing;
  logic             end_of_animation;

  modport source (output valid, output column, output row, output playing,
                  output end_of_animation, input ready);
  modport sink   (input valid, input column, input row, input playing,
                  input end_of_animation, output ready);
endinterface

/* rtl/ssfs_ctrl.sv */
// Sequencer: request accept, divider step count, response publish.
module ssfs_ctrl import ssfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  ssfs_sts_t sts_i,
  output ssfs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MAP  = 2'd2;
  localparam logic [1:0] ST_PUB  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = sts_i.need_div ? ST_DIV : ST_PUB;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAME_BITS - 1)) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map_load = 1'b1;
        state_d        = ST_PUB;
      end
      ST_PUB: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

/* rtl/ssfs_dp.sv */
// Datapath: configuration, animation state, serial divider and response register.
module ssfs_dp import ssfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [DT_W-1:0]       delta_time_i,
  input  ssfs_cmd_t             cmd_i,
  output ssfs_sts_t             sts_o,
  output logic [COL_W-1:0]      column_o,
  output logic [ROW_W-1:0]      row_o,
  output logic                  playing_o,
  output logic                  end_of_animation_o
);

  // Configuration
  logic [FCFG_W-1:0]   start_q, end_q;
  logic [COL_W-1:0]    cols_q;
  logic [PERIOD_W-1:0] period_q;
  logic                loop_q;

  // Animation state
  logic [TIME_BITS-1:0]    elapsed_q, elapsed_d;
  logic signed [OFS_W-1:0] offset_q, offset_d;
  logic                    running_q, running_d;
  logic                    ended_q, ended_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;

  // Divider
  logic [FRAME_BITS-1:0] dvd_q;
  logic [COL_W-1:0]      rem_q;
  logic [COL_W-1:0]      cols_eff;
  logic [COL_W:0]        shifted;
  logic                  ge;

  // Response register
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_play_q, out_end_q;

  logic [SUM_W-1:0]          sum;
  logic [TIME_BITS-1:0]      el_sat;
  logic                      adv;
  logic signed [ARITH_W-1:0] s_x, e_x, ofs_x, ofs_src, f_x, nxt_x, fn_x;
  logic                      fwd, beyond;
  logic [FRAME_BITS-1:0]     f_clamped;

  assign cols_eff = (cols_q == '0) ? COL_W'(1) : cols_q;

  always_comb begin
    sum    = SUM_W'(elapsed_q) + SUM_W'(delta_time_i);
    el_sat = (sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    adv    = CMP_W'(el_sat) >= CMP_W'(period_q);

    s_x     = $signed(ARITH_W'(start_q));
    e_x     = $signed(ARITH_W'(end_q));
    ofs_x   = ARITH_W'(offset_q);
    ofs_src = (operation_i == OP_PLAY) ? '0 : ofs_x;
    f_x     = s_x + ofs_src;
    if (f_x < 0) begin
      f_clamped = '0;
    end else if (f_x > $signed(ARITH_W'(FRAME_MAX))) begin
      f_clamped = '1;
    end else begin
      f_clamped = f_x[FRAME_BITS-1:0];
    end

    fwd    = start_q < end_q;
    nxt_x  = fwd ? (ofs_x + ARITH_W'(1)) : (ofs_x - ARITH_W'(1));
    fn_x   = s_x + nxt_x;
    beyond = fwd ? (fn_x > e_x) : (fn_x < e_x);

    sts_o.need_div = (operation_i == OP_PLAY) ||
                     ((operation_i == OP_TICK) && running_q && adv);
  end

  // State update at accept
  always_comb begin
    elapsed_d = elapsed_q;
    offset_d  = offset_q;
    running_d = running_q;
    ended_d   = ended_q;
    if (cmd_i.accept) begin
      unique case (operation_i)
        OP_TICK: begin
          ended_d = 1'b0;
          if (running_q) begin
            elapsed_d = el_sat;
            if (adv) begin
              elapsed_d = '0;
              if (beyond) begin
                offset_d = '0;
                if (!loop_q) begin
                  running_d = 1'b0;
                  ended_d   = 1'b1;
                end
              end else begin
                offset_d = nxt_x[OFS_W-1:0];
              end
            end
          end
        end
        OP_PLAY: begin
          running_d = 1'b1;
          offset_d  = '0;
        end
        OP_STOP: begin
          running_d = 1'b0;
          elapsed_d = '0;
          offset_d  = '0;
          ended_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Divider step and position map
  always_comb begin
    shifted = {rem_q, dvd_q[FRAME_BITS-1]};
    ge      = shifted >= {1'b0, cols_eff};
    col_d   = col_q;
    row_d   = row_q;
    if (cmd_i.map_load) begin
      if (rem_q == '0) begin
        col_d = cols_eff;
        row_d = (dvd_q == '0) ? '0 : ROW_W'(dvd_q - 1'b1);
      end else begin
        col_d = rem_q;
        row_d = ROW_W'(dvd_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= FCFG_W'(1);
      end_q     <= FCFG_W'(1);
      cols_q    <= COL_W'(1);
      period_q  <= PERIOD_W'(1);
      loop_q    <= 1'b0;
      elapsed_q <= '0;
      offset_q  <= '0;
      running_q <= 1'b0;
      ended_q   <= 1'b0;
      col_q     <= COL_W'(1);
      row_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START:  start_q  <= cfg_data_i[FCFG_W-1:0];
          REG_END:    end_q    <= cfg_data_i[FCFG_W-1:0];
          REG_COLS:   cols_q   <= cfg_data_i[COL_W-1:0];
          REG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          REG_LOOP:   loop_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      elapsed_q <= elapsed_d;
      offset_q  <= offset_d;
      running_q <= running_d;
      ended_q   <= ended_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  // Restoring divide, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dvd_q <= f_clamped;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[FRAME_BITS-2:0], ge};
      rem_q <= ge ? COL_W'(shifted - {1'b0, cols_eff}) : shifted[COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_play_q <= running_q;
      out_end_q  <= ended_q;
    end
  end

  assign column_o           = out_col_q;
  assign row_o              = out_row_q;
  assign playing_o          = out_play_q;
  assign end_of_animation_o = out_end_q;

endmodule

/* rtl/sprite_sheet_frame_sequencer.sv */
// A request without a frame change (stop, idle tick, unused code) is published
// directly; a frame change first runs the bit-serial divide of the frame number
// by the column count, then the position map. One request in flight; the next
// is taken once its response sits in the output register. Reset clears
// configuration to defaults and the control and animation state.
module sprite_sheet_frame_sequencer import ssfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssfs_req_if.sink              req,
  ssfs_rsp_if.source            rsp
);

  ssfs_cmd_t cmd;
  ssfs_sts_t sts;

  ssfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssfs_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (req.operation),
    .delta_time_i       (req.delta_time),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .column_o           (rsp.column),
    .row_o              (rsp.row),
    .playing_o          (rsp.playing),
    .end_of_animation_o (rsp.end_of_animation)
  );

endmodule

/* sim/sprite_position_checker.sv */
// Response checker for the sprite-sheet frame sequencer: tracks the animation and compares.
`timescale 1ns / 1ps

module sprite_position_checker import ssfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ssfs_req_if                   req,
  ssfs_rsp_if                   rsp,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    requests_o,
  output int                    frame_steps_o
);

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             playing;
    logic             ended;
  } sheet_pos_t;

  localparam longint unsigned ELAPSED_MAX = (64'd1 << TIME_BITS) - 1;

  // register copies
  logic [FCFG_W-1:0]   first_frame;
  logic [FCFG_W-1:0]   last_frame;
  logic [COL_W-1:0]    columns;
  logic [PERIOD_W-1:0] period;
  logic                wrap_en;

  // animation state
  logic [TIME_BITS-1:0] elapsed;
  int                   offset;
  logic                 running;
  logic                 ended;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;

  sheet_pos_t positions_due[$];

  function automatic void show_frame(int frame);
    int f;
    int ncols;
    int q;
    int r;
    ncols = (columns == 0) ? 1 : int'(columns);
    f = frame;
    if (f < 0) f = 0;
    if (f > FRAME_MAX) f = FRAME_MAX;
    q = f / ncols;
    r = f % ncols;
    // exact multiple lands in the last column of the previous row
    if (r == 0) begin
      cur_col = COL_W'(ncols);
      cur_row = (q == 0) ? '0 : ROW_W'(q - 1);
    end else begin
      cur_col = COL_W'(r);
      cur_row = ROW_W'(q);
    end
  endfunction

  function automatic void halt_animation();
    running = 1'b0;
    elapsed = '0;
    offset  = 0;
    ended   = 1'b1;
  endfunction

  function automatic sheet_pos_t step_animation(logic [OP_W-1:0] op, logic [DT_W-1:0] dt);
    longint unsigned sum;
    int s;
    int e;
    sheet_pos_t pos;
    s = int'(first_frame);
    e = int'(last_frame);
    case (op)
      OP_TICK: begin
        ended = 1'b0;
        if (running) begin
          sum = elapsed;
          sum += dt;
          if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
          elapsed = sum[TIME_BITS-1:0];
          if (elapsed >= period) begin
            show_frame(s + offset);
            frame_steps_o++;
            if (s < e) begin
              offset++;
              if (s + offset > e) begin
                if (wrap_en) offset = 0;
                else halt_animation();
              end
            end else begin
              offset--;
              if (s + offset < e) begin
                if (wrap_en) offset = 0;
                else halt_animation();
              end
            end
            elapsed = '0;
          end
        end
      end
      OP_PLAY: begin
        running = 1'b1;
        offset  = 0;
        show_frame(s);
      end
      OP_STOP: halt_animation();
      default: ;
    endcase
    pos.column  = cur_col;
    pos.row     = cur_row;
    pos.playing = running;
    pos.ended   = ended;
    return pos;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sheet_pos_t want;
    if (!rst_ni) begin
      first_frame   = 1;
      last_frame    = 1;
      columns       = 1;
      period        = 1;
      wrap_en       = 1'b0;
      elapsed       = '0;
      offset        = 0;
      running       = 1'b0;
      ended         = 1'b0;
      cur_col       = 1;
      cur_row       = '0;
      mismatches_o  = 0;
      frame_steps_o = 0;
      positions_due.delete();
      pending_o  <= 0;
      requests_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START:  first_frame = cfg_data_i[FCFG_W-1:0];
          REG_END:    last_frame  = cfg_data_i[FCFG_W-1:0];
          REG_COLS:   columns     = cfg_data_i[COL_W-1:0];
          REG_PERIOD: period      = cfg_data_i[PERIOD_W-1:0];
          REG_LOOP:   wrap_en     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (positions_due.size() == 0) begin
          $display("%0t: unrequested response, expected none, actual col %0d row %0d",
                   $time, rsp.column, rsp.row);
          mismatches_o++;
        end else begin
          want = positions_due.pop_front();
          check_field("column", 16'(want.column), 16'(rsp.column));
          check_field("row", 16'(want.row), 16'(rsp.row));
          check_field("playing", 16'(want.playing), 16'(rsp.playing));
          check_field("end_of_animation", 16'(want.ended), 16'(rsp.end_of_animation));
        end
      end
      if (req.valid && req.ready) begin
        positions_due.push_back(step_animation(req.operation, req.delta_time));
        requests_o <= requests_o + 1;
      end
      pending_o <= positions_due.size();
    end
  end

endmodule

/* sim/sprite_sheet_frame_sequencer_tb.sv */
// Top of the frame sequencer testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module sprite_sheet_frame_sequencer_tb;
  import ssfs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int REQ_TARGET   = 1050;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int mismatches;
  int pending;
  int requests_seen;
  int frame_steps;
  int sent;
  int settings_loaded;

  ssfs_req_if req_if ();
  ssfs_rsp_if rsp_if ();

  sprite_sheet_frame_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  sprite_position_checker pos_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req           (req_if),
    .rsp           (rsp_if),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .requests_o    (requests_seen),
    .frame_steps_o (frame_steps)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // response side: random stalls, plus one long hold so the block backs up
  initial begin : response_sink
    int  hold_left;
    bit  hold_done;
    int  idle_pct;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      idle_pct = (requests_seen < 350) ? 65 : (requests_seen < 700) ? 28 : 0;
      if (!hold_done && requests_seen >= 420) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic issue_request(logic [OP_W-1:0] op, logic [DT_W-1:0] dt);
    int idle_pct;
    idle_pct = (sent < 350) ? 28 : (sent < 700) ? 65 : 0;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.delta_time <= dt;
    do @(posedge clk_i); while (!req_if.ready);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic apply_settings(int start_f, int end_f, int cols, int period, bit wrap);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{REG_START, REG_END, REG_COLS, REG_PERIOD, REG_LOOP};
    vals = '{CFG_DATA_W'(start_f), CFG_DATA_W'(end_f), CFG_DATA_W'(cols),
             CFG_DATA_W'(period), CFG_DATA_W'(wrap)};
    wait_for_responses();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // one setting, a play, then mostly ticks with some plays, stops and unused codes
  task automatic run_phase(int count, bit long_period);
    int start_f;
    int end_f;
    int span;
    int cols;
    int period;
    int dt_cap;
    int pick;
    logic [OP_W-1:0] op;
    logic [DT_W-1:0] dt;
    start_f = $urandom_range(1, 4095);
    span    = $urandom_range(0, 12);
    pick    = $urandom_range(0, 9);
    if (pick == 0) begin
      start_f = 1;
      end_f   = 4095;
    end else if (pick == 1) begin
      start_f = 4095;
      end_f   = 1;
    end else if (pick < 6) begin
      end_f = (start_f + span > 4095) ? 4095 : start_f + span;
    end else begin
      end_f = (start_f - span < 1) ? 1 : start_f - span;
    end
    case ($urandom_range(0, 7))
      0: cols = 0;
      1: cols = 255;
      2: cols = 1;
      3: cols = $urandom_range(1, 255);
      default: cols = $urandom_range(2, 16);
    endcase
    case ($urandom_range(0, 5))
      0: period = 0;
      1: period = 1;
      2: period = $urandom_range(0, 24'hFFFFFF);
      default: period = $urandom_range(2, 400);
    endcase
    // full period: only a saturated time accumulator reaches it
    if (long_period) period = 24'hFFFFFF;
    dt_cap = (period > 400) ? 65535 : (period == 0) ? 50 : period;
    apply_settings(start_f, end_f, cols, period, 1'($urandom_range(0, 1)));
    issue_request(OP_PLAY, DT_W'($urandom));
    for (int i = 1; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (long_period || pick < 84) op = OP_TICK;
      else if (pick < 91) op = OP_PLAY;
      else if (pick < 96) op = OP_STOP;
      else op = OP_UNUSED;
      if (long_period) dt = ($urandom_range(0, 19) == 0) ? DT_W'($urandom) : '1;
      else if ($urandom_range(0, 9) == 0) dt = DT_W'($urandom);
      else dt = DT_W'($urandom_range(0, dt_cap));
      issue_request(op, dt);
    end
  endtask

  initial begin : stimulus
    bit long_done;
    long_done         = 1'b0;
    sent              = 0;
    settings_loaded   = 0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_START;
    cfg_data_i        <= '0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_TICK;
    req_if.delta_time <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: idle tick, unused code, stop, end flag cleared by tick
    issue_request(OP_TICK, 16'd0);
    issue_request(OP_UNUSED, 16'hFFFF);
    issue_request(OP_STOP, 16'd0);
    issue_request(OP_TICK, 16'hFFFF);

    // zero period, looping at the top of the frame range; leaves the offset at 4
    apply_settings(4090, 4095, 255, 0, 1'b1);
    issue_request(OP_PLAY, 16'd0);
    repeat (4) issue_request(OP_TICK, 16'd0);

    // single frame under a carried offset: frames past the top clamp, zero columns
    apply_settings(4095, 4095, 0, 1, 1'b0);
    repeat (5) issue_request(OP_TICK, 16'd1);

    // backward play, one tick short of the period first
    apply_settings(5, 1, 3, 2, 1'b0);
    issue_request(OP_PLAY, 16'd7);
    issue_request(OP_TICK, 16'd1);
    issue_request(OP_TICK, 16'd1);
    issue_request(OP_TICK, 16'd2);

    // carried negative offset drops the frame number to zero
    apply_settings(1, 1, 3, 2, 1'b0);
    issue_request(OP_TICK, 16'd2);
    issue_request(OP_PLAY, 16'd0);
    issue_request(OP_STOP, 16'd0);

    // forward to the range end without looping
    apply_settings(1, 2, 1, 1, 1'b0);
    issue_request(OP_PLAY, 16'd0);
    issue_request(OP_TICK, 16'd1);
    issue_request(OP_TICK, 16'd1);

    while (sent < REQ_TARGET) begin
      if (!long_done && sent >= 600) begin
        run_phase(300, 1'b1);
        long_done = 1'b1;
      end else begin
        run_phase($urandom_range(40, 90), 1'b0);
      end
    end

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over %0d register settings, %0d frame steps,",
             requests_seen, settings_loaded, frame_steps);
    $display("both stall mixes on the channels, a full-speed stretch and one long output hold.");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
